>>> hw/rtl/rxh_pkg.sv
// Shared types, constants and helpers for the rotate/xor 128-bit hash stream.
package rxh_pkg;

    localparam int unsigned BLOCK_WORDS = 12;
    localparam logic [30:0] SHORT_LIMIT_BYTES = 31'd192;
    localparam logic [63:0] FILL_CONST = 64'hdeadbeefdeadbeef;

    localparam logic [5:0] MIX_ROT [BLOCK_WORDS] = '{
        6'd11, 6'd32, 6'd43, 6'd31, 6'd17, 6'd28,
        6'd39, 6'd57, 6'd55, 6'd54, 6'd22, 6'd46
    };
    localparam logic [5:0] END_ROT [6] = '{6'd44, 6'd15, 6'd34, 6'd21, 6'd13, 6'd38};

    localparam logic [2:0] OP_NONE   = 3'd0;
    localparam logic [2:0] OP_WORD   = 3'd1;
    localparam logic [2:0] OP_SFIN1  = 3'd2;
    localparam logic [2:0] OP_SFIN2  = 3'd3;
    localparam logic [2:0] OP_ROT    = 3'd4;
    localparam logic [2:0] OP_ADDLEN = 3'd5;
    localparam logic [2:0] OP_MIX    = 3'd6;
    localparam logic [2:0] OP_END    = 3'd7;

    typedef struct packed {
        logic [2:0] op;
        logic       word_add;
        logic [3:0] step;
        logic       out_load;
    } rxh_cmd_t;

    typedef struct packed {
        logic short_now;
        logic nz;
        logic full;
    } rxh_status_t;

    function automatic logic [63:0] rotl(input logic [63:0] x, input logic [5:0] r);
        logic [127:0] tmp;
        tmp = {x, x} << r;
        return tmp[127:64];
    endfunction

endpackage

>>> hw/rtl/rxh_datapath.sv
// Datapath: seeds, twelve-word state, short-path lanes and result register.
module rxh_datapath
    import rxh_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic               cfg_index,
    input  logic [63:0]        cfg_data,
    input  logic [63:0]        word,
    input  logic [3:0]         byte_count,
    input  logic               first,
    input  logic [30:0]        message_length,
    input  rxh_cmd_t           cmd,
    output rxh_status_t        status,
    output logic [63:0]        hash_high,
    output logic [63:0]        hash_low,
    output logic [63:0]        hash_folded
);

    logic [63:0] seed_one_reg, seed_two_reg;
    logic [63:0] st_reg [BLOCK_WORDS];
    logic [63:0] st_next [BLOCK_WORDS];
    logic [63:0] base [BLOCK_WORDS];
    logic [30:0] len_reg, len_next;
    logic        short_reg, short_next;
    logic [63:0] ta_reg, ta_next, tb_reg, tb_next;
    logic [63:0] hh_reg, hl_reg, hf_reg;
    logic [3:0]  n4;
    logic [63:0] wm;
    logic        short_now;

    always_comb
    begin
        n4 = (byte_count > 4'd8) ? 4'd8 : byte_count;
        for (int b = 0; b < 8; b++)
        begin
            wm[8*b +: 8] = (4'(b) < n4) ? word[8*b +: 8] : 8'd0;
        end
        short_now = first ? (message_length <= SHORT_LIMIT_BYTES) : short_reg;
        status.short_now = short_now;
        status.nz = (n4 != 4'd0);
        status.full = (n4 == 4'd8);
        for (int j = 0; j < BLOCK_WORDS; j++)
        begin
            if (first)
            begin
                base[j] = (j == 0) ? seed_one_reg : ((j == 1) ? seed_two_reg : FILL_CONST);
            end
            else
            begin
                base[j] = st_reg[j];
            end
        end
    end

    always_comb
    begin
        logic [63:0] a, b, t0, t1;
        a = 64'd0;
        b = 64'd0;
        t0 = 64'd0;
        t1 = 64'd0;
        st_next = st_reg;
        len_next = len_reg;
        short_next = short_reg;
        ta_next = ta_reg;
        tb_next = tb_reg;
        unique case (cmd.op)
            OP_WORD:
            begin
                st_next = base;
                if (first)
                begin
                    len_next = message_length;
                    short_next = short_now;
                end
                if (short_now)
                begin
                    if (status.nz)
                    begin
                        if (status.full)
                        begin
                            a = rotl(base[0] ^ wm, 6'd50) + base[1];
                            b = rotl(base[1], 6'd52) ^ a;
                        end
                        else
                        begin
                            a = rotl(base[0] ^ wm, 6'd36) + base[1];
                            b = rotl(base[1], 6'd19) ^ a;
                        end
                        st_next[0] = a;
                        st_next[1] = b;
                    end
                end
                else if (cmd.word_add)
                begin
                    t0 = base[0] + wm;
                    for (int j = 0; j < BLOCK_WORDS - 1; j++)
                    begin
                        st_next[j] = base[j+1];
                    end
                    st_next[BLOCK_WORDS-1] = t0;
                end
            end
            OP_SFIN1:
            begin
                a = rotl(st_reg[0] ^ FILL_CONST, 6'd24) + (st_reg[1] ^ FILL_CONST);
                b = rotl(st_reg[1] ^ FILL_CONST, 6'd36) ^ a;
                ta_next = a;
                tb_next = b;
            end
            OP_SFIN2:
            begin
                a = rotl(ta_reg, 6'd13) + tb_reg;
                b = rotl(tb_reg, 6'd7) ^ a;
                ta_next = a;
                tb_next = b;
            end
            OP_ROT:
            begin
                for (int j = 0; j < BLOCK_WORDS - 1; j++)
                begin
                    st_next[j] = st_reg[j+1];
                end
                st_next[BLOCK_WORDS-1] = st_reg[0];
            end
            OP_ADDLEN:
            begin
                st_next[BLOCK_WORDS-1] = st_reg[BLOCK_WORDS-1] + {33'd0, len_reg};
            end
            OP_MIX:
            begin
                t0 = rotl(st_reg[0] ^ st_reg[BLOCK_WORDS-1], MIX_ROT[cmd.step]);
                t1 = st_reg[BLOCK_WORDS-1] + t0;
                for (int j = 0; j < BLOCK_WORDS - 2; j++)
                begin
                    st_next[j] = st_reg[j+1];
                end
                st_next[BLOCK_WORDS-2] = t1;
                st_next[BLOCK_WORDS-1] = t0;
            end
            OP_END:
            begin
                t0 = st_reg[0] + st_reg[1];
                t1 = rotl(st_reg[1], END_ROT[cmd.step[2:0]]) ^ t0;
                for (int j = 0; j < BLOCK_WORDS - 2; j++)
                begin
                    st_next[j] = st_reg[j+2];
                end
                st_next[BLOCK_WORDS-2] = t0;
                st_next[BLOCK_WORDS-1] = t1;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_one_reg <= FILL_CONST;
            seed_two_reg <= FILL_CONST;
            for (int j = 0; j < BLOCK_WORDS; j++)
            begin
                st_reg[j] <= 64'd0;
            end
            len_reg <= 31'd0;
            short_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we && !cfg_index)
            begin
                seed_one_reg <= cfg_data;
            end
            if (cfg_we && cfg_index)
            begin
                seed_two_reg <= cfg_data;
            end
            st_reg <= st_next;
            len_reg <= len_next;
            short_reg <= short_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ta_reg <= ta_next;
        tb_reg <= tb_next;
        if (cmd.out_load)
        begin
            if (short_reg)
            begin
                hh_reg <= ta_reg;
                hl_reg <= tb_reg;
                hf_reg <= ta_reg ^ tb_reg;
            end
            else
            begin
                hh_reg <= st_reg[0] ^ st_reg[1] ^ st_reg[2] ^ st_reg[3];
                hl_reg <= st_reg[4] ^ st_reg[5] ^ st_reg[6] ^ st_reg[7];
                hf_reg <= st_reg[0] ^ st_reg[1] ^ st_reg[2] ^ st_reg[3]
                        ^ st_reg[4] ^ st_reg[5] ^ st_reg[6] ^ st_reg[7];
            end
        end
    end

    assign hash_high = hh_reg;
    assign hash_low = hl_reg;
    assign hash_folded = hf_reg;

endmodule

>>> hw/rtl/rxh_ctrl.sv
// Controller: sequences word steps, block mixes, tail alignment and end rounds.
module rxh_ctrl
    import rxh_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        first,
    input  logic        last,
    input  rxh_status_t status,
    output rxh_cmd_t    cmd,
    output logic        out_valid,
    input  logic        out_ready
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SFIN1 = 3'd1;
    localparam logic [2:0] S_SFIN2 = 3'd2;
    localparam logic [2:0] S_ALIGN = 3'd3;
    localparam logic [2:0] S_MIX   = 3'd4;
    localparam logic [2:0] S_END   = 3'd5;
    localparam logic [2:0] S_EMIT  = 3'd6;

    localparam logic [3:0] LAST_SLOT = 4'(BLOCK_WORDS - 1);

    logic [2:0] state_reg, state_next;
    logic [3:0] idx_reg, idx_next;
    logic [3:0] cnt_reg, cnt_next;
    logic [1:0] rnd_reg, rnd_next;
    logic       last_pend_reg, last_pend_next;
    logic       final_reg, final_next;
    logic       out_valid_reg, out_valid_next;
    logic [3:0] idx_eff;
    logic       add;

    assign in_ready = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        idx_eff = first ? 4'd0 : idx_reg;
        add = !status.short_now && status.nz && !(idx_eff == LAST_SLOT && last && !status.full);
        state_next = state_reg;
        idx_next = idx_reg;
        cnt_next = cnt_reg;
        rnd_next = rnd_reg;
        last_pend_next = last_pend_reg;
        final_next = final_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd = '0;
        cmd.op = OP_NONE;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.op = OP_WORD;
                    cmd.word_add = add;
                    if (status.short_now)
                    begin
                        idx_next = last ? 4'd0 : idx_eff;
                        if (last)
                        begin
                            state_next = S_SFIN1;
                        end
                    end
                    else if (add && idx_eff == LAST_SLOT)
                    begin
                        idx_next = 4'd0;
                        cnt_next = 4'd0;
                        final_next = 1'b0;
                        last_pend_next = last;
                        state_next = S_MIX;
                    end
                    else
                    begin
                        idx_next = add ? idx_eff + 4'd1 : idx_eff;
                        if (last)
                        begin
                            state_next = S_ALIGN;
                        end
                    end
                end
            end
            S_SFIN1:
            begin
                cmd.op = OP_SFIN1;
                state_next = S_SFIN2;
            end
            S_SFIN2:
            begin
                cmd.op = OP_SFIN2;
                state_next = S_EMIT;
            end
            S_ALIGN:
            begin
                if (idx_reg == 4'd0)
                begin
                    cmd.op = OP_ADDLEN;
                    final_next = 1'b1;
                    cnt_next = 4'd0;
                    state_next = S_MIX;
                end
                else
                begin
                    cmd.op = OP_ROT;
                    idx_next = (idx_reg == LAST_SLOT) ? 4'd0 : idx_reg + 4'd1;
                end
            end
            S_MIX:
            begin
                cmd.op = OP_MIX;
                cmd.step = cnt_reg;
                if (cnt_reg == LAST_SLOT)
                begin
                    cnt_next = 4'd0;
                    rnd_next = 2'd0;
                    if (final_reg)
                    begin
                        state_next = S_END;
                    end
                    else if (last_pend_reg)
                    begin
                        state_next = S_ALIGN;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
                else
                begin
                    cnt_next = cnt_reg + 4'd1;
                end
            end
            S_END:
            begin
                cmd.op = OP_END;
                cmd.step = cnt_reg;
                if (cnt_reg == 4'd5)
                begin
                    cnt_next = 4'd0;
                    if (rnd_reg == 2'd2)
                    begin
                        state_next = S_EMIT;
                    end
                    else
                    begin
                        rnd_next = rnd_reg + 2'd1;
                    end
                end
                else
                begin
                    cnt_next = cnt_reg + 4'd1;
                end
            end
            S_EMIT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load = 1'b1;
                    out_valid_next = 1'b1;
                    idx_next = 4'd0;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            idx_reg <= 4'd0;
            cnt_reg <= 4'd0;
            rnd_reg <= 2'd0;
            last_pend_reg <= 1'b0;
            final_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg <= idx_next;
            cnt_reg <= cnt_next;
            rnd_reg <= rnd_next;
            last_pend_reg <= last_pend_next;
            final_reg <= final_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

>>> hw/rtl/rotate_xor_hash128_stream.sv
// Top level of the streaming 128-bit rotate/add/xor hash.
//   channel | dir | tdata                                     | tuser | tlast
//   s_axis  | in  | word, byte_count, message_length           | first | last
//   m_axis  | out | hash_high, hash_low, hash_folded          | -     | -
//   cfg     | in  | cfg_index 0: seed_one, 1: seed_two, cfg_data 64 bits
// One word per cycle while idle; a word that completes a 96-byte block starts a block mix, during which input waits.
// Short-path last word: finish steps SFIN1 and SFIN2, then the emit step. Long-path last word: alignment
// rotations, a length add, a block mix and the end rounds, all on the one mix unit.
// Reset clears the state words and index; seeds reset to 0xdeadbeefdeadbeef.
// A held result stalls only the final emit step; input is taken again once it is loaded.
module rotate_xor_hash128_stream
    import rxh_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [103:0] s_axis_tdata,  // word[63:0], byte_count[67:64], message_length[98:68]
    input  logic         s_axis_tuser,  // first
    input  logic         s_axis_tlast,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [191:0] m_axis_tdata,  // hash_high[63:0], hash_low[127:64], hash_folded[191:128]
    input  logic         cfg_we,
    input  logic         cfg_index,
    input  logic [63:0]  cfg_data
);

    rxh_cmd_t    cmd;
    rxh_status_t status;
    logic [63:0] hash_high, hash_low, hash_folded;
    logic        in_ready;

    assign s_axis_tready = in_ready;
    assign m_axis_tdata = {hash_folded, hash_low, hash_high};

    rxh_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (in_ready),
        .first     (s_axis_tuser),
        .last      (s_axis_tlast),
        .status    (status),
        .cmd       (cmd),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready)
    );

    rxh_datapath u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .word           (s_axis_tdata[63:0]),
        .byte_count     (s_axis_tdata[67:64]),
        .first          (s_axis_tuser),
        .message_length (s_axis_tdata[98:68]),
        .cmd            (cmd),
        .status         (status),
        .hash_high      (hash_high),
        .hash_low       (hash_low),
        .hash_folded    (hash_folded)
    );

endmodule

>>> hw/rtl/rxh_checker.sv
// Port-level checks for the hash stream, bound to the top level.
module rxh_checker (
    input logic         clk,
    input logic         rst_n,
    input logic         s_axis_tvalid,
    input logic         s_axis_tready,
    input logic         s_axis_tlast,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [191:0] m_axis_tdata
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result beat dropped while stalled");

    a_fold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[191:128] == (m_axis_tdata[63:0] ^ m_axis_tdata[127:64]))
        else $error("folded hash mismatch");

    a_busy_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready && s_axis_tlast |=> !s_axis_tready)
        else $error("input taken during finalization");

    a_emit_from_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> !$past(s_axis_tready))
        else $error("result appeared without finalization");

endmodule

bind rotate_xor_hash128_stream rxh_checker u_rxh_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

>>> verif/tb_top.sv
// Testbench for the streaming rotate/add/xor 128-bit hash: directed and random messages.
module tb_top;

    typedef struct packed {
        logic [63:0] folded;
        logic [63:0] low;
        logic [63:0] high;
    } hash_t;

    localparam logic [63:0] FILL = 64'hdeadbeefdeadbeef;
    localparam int IDLE_LIMIT = 20000;

    logic clk;
    logic rst_n;
    logic s_axis_tvalid;
    logic s_axis_tready;
    logic [103:0] s_axis_tdata;
    logic s_axis_tuser;
    logic s_axis_tlast;
    logic m_axis_tvalid;
    logic m_axis_tready;
    logic [191:0] m_axis_tdata;
    logic cfg_we;
    logic cfg_index;
    logic [63:0] cfg_data;

    logic [63:0] seed_a;
    logic [63:0] seed_b;
    logic [63:0] st [12];
    int unsigned widx;
    logic [30:0] len_held;
    logic short_mode;

    hash_t hash_q [$];
    int errors;
    int idle_cycles;
    int hold_off;
    int rx_wait;
    bit draw_gaps;

    rotate_xor_hash128_stream dut (.*);

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic logic [63:0] rol(input logic [63:0] x, input int r);
        r = r & 63;
        if (r == 0)
            return x;
        return (x << r) | (x >> (64 - r));
    endfunction

    function automatic void mix_block();
        int p;
        int rots [12];
        rots = '{11, 32, 43, 31, 17, 28, 39, 57, 55, 54, 22, 46};
        for (int i = 0; i < 12; i++)
        begin
            p = (i + 11) % 12;
            st[i] = rol(st[i] ^ st[p], rots[i]);
            st[p] = st[p] + st[i];
        end
    endfunction

    function automatic void hash_word(input logic [63:0] w_in, input logic [3:0] cnt,
                                      input bit fst, input bit lst, input logic [30:0] len);
        logic [63:0] w;
        logic [63:0] a;
        logic [63:0] b;
        int n;
        int erot [6];
        hash_t h;
        erot = '{44, 15, 34, 21, 13, 38};
        w = w_in;
        n = (cnt > 8) ? 8 : cnt;
        if (n < 8)
            w = w & ((64'd1 << (8 * n)) - 64'd1);
        if (fst)
        begin
            for (int i = 0; i < 12; i++)
                st[i] = FILL;
            st[0] = seed_a;
            st[1] = seed_b;
            len_held = len;
            short_mode = (len <= 31'd192);
            widx = 0;
        end
        if (short_mode)
        begin
            a = st[0];
            b = st[1];
            if (n == 8)
            begin
                a = rol(a ^ w, 50) + b;
                b = rol(b, 52) ^ a;
            end
            else if (n > 0)
            begin
                a = rol(a ^ w, 36) + b;
                b = rol(b, 19) ^ a;
            end
            st[0] = a;
            st[1] = b;
            if (!lst)
                return;
            a = rol(a ^ FILL, 24);
            b = b ^ FILL;
            a = a + b;
            b = rol(b, 36) ^ a;
            a = rol(a, 13) + b;
            b = rol(b, 7) ^ a;
            h.high = a;
            h.low = b;
        end
        else
        begin
            if (widx >= 12)
                widx = 0;
            if (n > 0 && !(widx == 11 && lst && n < 8))
            begin
                st[widx] = st[widx] + w;
                widx++;
                if (widx >= 12)
                begin
                    mix_block();
                    widx = 0;
                end
            end
            if (!lst)
                return;
            st[11] = st[11] + {33'd0, len_held};
            mix_block();
            for (int r = 0; r < 3; r++)
                for (int k = 0; k < 6; k++)
                begin
                    st[2*k] = st[2*k] + st[2*k+1];
                    st[2*k+1] = rol(st[2*k+1], erot[k]) ^ st[2*k];
                end
            h.high = st[0] ^ st[1] ^ st[2] ^ st[3];
            h.low = st[4] ^ st[5] ^ st[6] ^ st[7];
        end
        widx = 0;
        h.folded = h.high ^ h.low;
        hash_q.push_back(h);
    endfunction

    task automatic send_word(input logic [63:0] w, input logic [3:0] cnt, input bit fst,
                             input bit lst, input logic [30:0] len);
        int gap;
        gap = draw_gaps ? $urandom_range(0, 17) : 0;
        if ($urandom_range(0, 3) == 0)
            gap = 0;
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {5'd0, len, cnt, w};
        s_axis_tuser <= fst;
        s_axis_tlast <= lst;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        hash_word(w, cnt, fst, lst, len);
    endtask

    task automatic end_stream();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic drain();
        end_stream();
        while (hash_q.size() != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
    endtask

    task automatic write_seed(input logic idx, input logic [63:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        if (idx)
            seed_b = val;
        else
            seed_a = val;
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // with rand_hi set, bytes beyond the count are left random so masking is exercised
    task automatic send_message(input int nbytes, input int len, input bit rand_hi);
        int nw;
        int rem;
        logic [63:0] w;
        nw = (nbytes + 7) / 8;
        if (nw == 0)
        begin
            send_word(rand_hi ? rand64() : 64'd0, 4'd0, 1'b1, 1'b1, len[30:0]);
            return;
        end
        for (int i = 0; i < nw; i++)
        begin
            rem = nbytes - 8 * i;
            w = rand64();
            if (rem < 8 && !rand_hi)
                w = w & ((64'd1 << (8 * rem)) - 64'd1);
            send_word(w, (rem >= 8) ? 4'd8 : rem[3:0], i == 0, i == nw - 1, len[30:0]);
        end
    endtask

    task automatic test_unseeded_start();
        send_word(64'hffffffffffffffff, 4'd8, 1'b0, 1'b0, 31'd0);
        send_word(64'h0, 4'd3, 1'b0, 1'b1, 31'h7fffffff);
        drain();
    endtask

    task automatic test_directed();
        send_message(0, 0, 0);
        send_message(5, 5, 1);
        send_word(rand64(), 4'd15, 1'b1, 1'b1, 31'd8);
        send_message(192, 192, 0);
        send_message(193, 193, 1);
        send_message(96, 96, 0);
        send_message(95, 300, 1);
        send_message(96, 300, 0);
        // short word mid-message on both paths
        send_word(rand64(), 4'd4, 1'b1, 1'b0, 31'd40);
        send_word(rand64(), 4'd8, 1'b0, 1'b1, 31'd40);
        send_word(rand64(), 4'd4, 1'b1, 1'b0, 31'd400);
        send_word(rand64(), 4'd0, 1'b0, 1'b0, 31'd400);
        send_word(rand64(), 4'd8, 1'b0, 1'b1, 31'd400);
        send_message(16, 31'h7fffffff, 0);
        drain();
    endtask

    task automatic test_random(input int count);
        int sent;
        int nb;
        sent = 0;
        while (sent < count)
        begin
            case ($urandom_range(0, 9))
                0: nb = $urandom_range(0, 8);
                1, 2, 3: nb = $urandom_range(0, 192);
                4: nb = 96 * $urandom_range(1, 3) - $urandom_range(0, 8);
                9:
                begin
                    send_word(rand64(), 4'($urandom_range(0, 15)), 1'($urandom_range(0, 1)),
                              1'($urandom_range(0, 1)), 31'($urandom_range(0, 400)));
                    sent++;
                    continue;
                end
                default: nb = $urandom_range(0, 400);
            endcase
            if ($urandom_range(0, 7) == 0)
                send_message(nb, $urandom_range(0, 500), 1'($urandom_range(0, 1)));
            else
                send_message(nb, nb, 1'($urandom_range(0, 1)));
            sent += (nb + 7) / 8 + (nb == 0);
        end
        drain();
    endtask

    task automatic test_backpressure();
        hold_off = 300;
        send_message(20, 20, 0);
        send_message(8, 8, 0);
        send_message(300, 300, 0);
        drain();
    endtask

    always @(posedge clk)
    begin
        int gap;
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            rx_wait <= 0;
        end
        else if (hold_off > 0)
        begin
            hold_off <= hold_off - 1;
            m_axis_tready <= 1'b0;
        end
        else if (m_axis_tvalid && m_axis_tready)
        begin
            gap = draw_gaps ? $urandom_range(0, 17) : 0;
            rx_wait <= gap;
            m_axis_tready <= (gap == 0);
        end
        else if (rx_wait > 0)
        begin
            rx_wait <= rx_wait - 1;
            m_axis_tready <= (rx_wait == 1);
        end
        else
            m_axis_tready <= 1'b1;
    end

    always @(posedge clk)
    begin
        hash_t exp;
        hash_t got;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got = m_axis_tdata;
            if (hash_q.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected hash %h", got);
            end
            else
            begin
                exp = hash_q.pop_front();
                if (got.high !== exp.high || got.low !== exp.low
                    || got.folded !== exp.folded)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("hash mismatch exp %h got %h", exp, got);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > IDLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = 1'b0;
        s_axis_tlast = 1'b0;
        cfg_we = 1'b0;
        cfg_index = 1'b0;
        cfg_data = '0;
        errors = 0;
        idle_cycles = 0;
        hold_off = 0;
        draw_gaps = 1'b0;
        seed_a = FILL;
        seed_b = FILL;
        for (int i = 0; i < 12; i++)
            st[i] = '0;
        widx = 0;
        len_held = '0;
        short_mode = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_unseeded_start();
        test_directed();
        draw_gaps = 1'b1;
        test_backpressure();
        write_seed(1'b0, 64'd0);
        write_seed(1'b1, 64'hffffffffffffffff);
        test_directed();
        test_random(220);
        write_seed(1'b0, rand64());
        write_seed(1'b1, rand64());
        test_random(220);
        write_seed(1'b0, 64'hffffffffffffffff);
        write_seed(1'b1, 64'd0);
        draw_gaps = 1'b0;
        test_random(110);
        draw_gaps = 1'b1;
        test_random(110);

        if (errors == 0 && hash_q.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end
endmodule
